>>> rtl/uhrs_pkg.sv
package uhrs_pkg;

  localparam int IO_W       = 32;  // width of temperature, velocity and residual ports
  localparam int IDX_W      = 10;  // width of the result column/row fields
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_SIZE_W = 11;
  localparam int COEF_W     = 31;
  localparam int STEP_W     = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRANDTL     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEATED      = 3'd7;

  // which rule gives the first residual of a task
  typedef enum logic [1:0] {
    KIND_LEFT,
    KIND_RIGHT,
    KIND_BOTTOM,
    KIND_INNER
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             has_second;  // last row: the point itself follows
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;         // row of the first residual
  } task_ctrl_t;

  localparam int CTRL_W = $bits(task_ctrl_t);

endpackage

>>> rtl/uhrs_queue.sv
module uhrs_queue import uhrs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/uhrs_front.sv
module uhrs_front import uhrs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [IO_W-1:0]       in_temperature,
  input  logic signed [IO_W-1:0]       in_vel_x,
  input  logic signed [IO_W-1:0]       in_vel_y,
  input  logic                         size_wr,
  input  logic [CFG_SIZE_W-1:0]        grid_width,
  input  logic [CFG_SIZE_W-1:0]        grid_height,
  input  logic                         q_full,
  output logic                         q_push,
  output task_ctrl_t                   q_ctrl,
  output logic [7*DATA_WIDTH-1:0]      q_data
);

  localparam int DW  = DATA_WIDTH;
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EWW = ($clog2(MAX_WIDTH + 1) > CFG_SIZE_W) ? $clog2(MAX_WIDTH + 1) : CFG_SIZE_W;
  localparam int EHW = ($clog2(MAX_HEIGHT + 1) > CFG_SIZE_W) ? $clog2(MAX_HEIGHT + 1) : CFG_SIZE_W;
  localparam int SW  = IO_W + DW;
  localparam logic signed [SW-1:0] DMAX = (SW'(1) <<< (DW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] DMIN = -DMAX - SW'(1);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_RD   = 1'b1;

  function automatic logic signed [DW-1:0] sat_in(input logic signed [IO_W-1:0] v);
    logic signed [SW-1:0] x;
    x = SW'(v);
    if (x > DMAX) return DMAX[DW-1:0];
    if (x < DMIN) return DMIN[DW-1:0];
    return x[DW-1:0];
  endfunction

  logic                 fstate_r;
  logic [AW-1:0]        col_r;
  logic [RW-1:0]        row_r;
  logic [EWW-1:0]       w_ext, w_eff;
  logic [EHW-1:0]       h_ext, h_eff;
  logic                 col_last, row_last;
  logic                 accept, mem_wr;
  logic [AW-1:0]        ic, il, ir;

  logic signed [DW-1:0] t_r, vx_r, vy_r;
  logic [AW-1:0]        ic_r;
  logic                 has_res_r;
  task_ctrl_t           ctrl_r;

  logic signed [DW-1:0] prev_mem  [MAX_WIDTH];
  logic signed [DW-1:0] prev2_mem [MAX_WIDTH];
  logic [2*DW-1:0]      vel_mem   [MAX_WIDTH];
  logic signed [DW-1:0] prev_c_r, prev_r_r, prev2_c_r, prev2_l_r;
  logic [2*DW-1:0]      vel_c_r;

  assign w_ext = EWW'(grid_width);
  assign h_ext = EHW'(grid_height);
  assign w_eff = (w_ext < EWW'(3)) ? EWW'(3) :
                 (w_ext > EWW'(MAX_WIDTH)) ? EWW'(MAX_WIDTH) : w_ext;
  assign h_eff = (h_ext < EHW'(3)) ? EHW'(3) :
                 (h_ext > EHW'(MAX_HEIGHT)) ? EHW'(MAX_HEIGHT) : h_ext;
  assign col_last = (EWW'(col_r) == w_eff - EWW'(1));
  assign row_last = (EHW'(row_r) == h_eff - EHW'(1));

  assign in_stall = (fstate_r != F_IDLE);
  assign accept   = in_valid && !in_stall;

  assign ic = col_r;
  assign il = (col_r == '0) ? '0 : col_r - AW'(1);
  assign ir = col_last ? '0 : col_r + AW'(1);

  assign q_push = (fstate_r == F_RD) && has_res_r && !q_full;
  assign mem_wr = (fstate_r == F_RD) && !(has_res_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r <= F_IDLE;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (size_wr) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        if (col_last) begin
          col_r <= '0;
          row_r <= row_last ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + AW'(1);
        end
      end
      unique case (fstate_r)
        F_IDLE:  if (accept) fstate_r <= F_RD;
        F_RD:    if (mem_wr) fstate_r <= F_IDLE;
        default: fstate_r <= F_IDLE;
      endcase
    end
  end

  // item capture and classification
  always_ff @(posedge clk) begin
    if (accept) begin
      t_r       <= sat_in(in_temperature);
      vx_r      <= sat_in(in_vel_x);
      vy_r      <= sat_in(in_vel_y);
      ic_r      <= ic;
      has_res_r <= (row_r != '0);
      ctrl_r.has_second <= row_last;
      ctrl_r.col        <= IDX_W'(col_r);
      ctrl_r.row        <= IDX_W'(row_r - RW'(1));
      if (col_r == '0)                  ctrl_r.kind <= KIND_LEFT;
      else if (col_last)                ctrl_r.kind <= KIND_RIGHT;
      else if (row_r == RW'(1))         ctrl_r.kind <= KIND_BOTTOM;
      else                              ctrl_r.kind <= KIND_INNER;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_c_r <= prev_mem[ic];
      prev_r_r <= prev_mem[ir];
    end
    if (mem_wr) prev_mem[ic_r] <= t_r;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev2_c_r <= prev2_mem[ic];
      prev2_l_r <= prev2_mem[il];
    end
    if (mem_wr) prev2_mem[ic_r] <= prev_c_r;
  end

  always_ff @(posedge clk) begin
    if (accept) vel_c_r <= vel_mem[ic];
    if (mem_wr) vel_mem[ic_r] <= {vx_r, vy_r};
  end

  assign q_ctrl = ctrl_r;
  // t, l, r, d, u, vx, vy from the top down
  assign q_data = {prev_c_r, prev2_l_r, prev_r_r, prev2_c_r, t_r, vel_c_r};

endmodule

>>> rtl/uhrs_back.sv
module uhrs_back import uhrs_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  task_ctrl_t               q_ctrl,
  input  logic [7*DATA_WIDTH-1:0]  q_data,
  input  logic [COEF_W-1:0]        coef_xx,
  input  logic [COEF_W-1:0]        coef_yy,
  input  logic [STEP_W-1:0]        step_x,
  input  logic [STEP_W-1:0]        step_y,
  input  logic [COEF_W-1:0]        prandtl,
  input  logic                     heated_flag,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [IO_W-1:0]   out_residual,
  output logic [IDX_W-1:0]         out_res_col,
  output logic [IDX_W-1:0]         out_res_row,
  output logic                     out_last
);

  localparam int DW = DATA_WIDTH;
  localparam int BW = (DW > 32) ? DW : 32;
  localparam int MW = DW + BW;
  localparam int PW = MW + 1;
  localparam logic signed [PW-1:0] DMAX = (PW'(1) <<< (DW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] DMIN = -DMAX - PW'(1);
  localparam logic [3:0] LAST_STEP = 4'd8;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_OUT1 = 2'd2;
  localparam logic [1:0] B_OUT2 = 2'd3;

  function automatic logic signed [PW-1:0] ext(input logic signed [DW-1:0] v);
    return PW'(v);
  endfunction

  function automatic logic signed [DW-1:0] sat_p(input logic signed [PW-1:0] v);
    if (v > DMAX) return DMAX[DW-1:0];
    if (v < DMIN) return DMIN[DW-1:0];
    return v[DW-1:0];
  endfunction

  logic signed [DW-1:0] h_t, h_l, h_r, h_d, h_u, h_vx, h_vy;
  logic signed [PW-1:0] heat;

  assign h_t  = q_data[6*DW +: DW];
  assign h_l  = q_data[5*DW +: DW];
  assign h_r  = q_data[4*DW +: DW];
  assign h_d  = q_data[3*DW +: DW];
  assign h_u  = q_data[2*DW +: DW];
  assign h_vx = q_data[DW +: DW];
  assign h_vy = q_data[0 +: DW];
  assign heat = heated_flag ? (PW'(1) <<< FRAC_BITS) : '0;

  logic [1:0]           bstate_r;
  task_ctrl_t           ctrl_r;
  logic signed [DW-1:0] dxx_r, dyy_r, dtl_r, drt_r, dtd_r, dut_r;
  logic signed [DW-1:0] vxp_r, vxm_r, vyp_r, vym_r;
  logic signed [DW-1:0] res1_r, res2_r;
  logic signed [DW-1:0] diff_r, tmp_r, ax_r, ay_r;
  logic [3:0]           step_r;
  logic                 phase_r;
  logic signed [DW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [MW-1:0] prod, prod_r;
  logic signed [PW-1:0] prod_sh;
  logic signed [DW-1:0] mq;
  logic                 out_load;
  logic                 out_fire;
  logic signed [DW-1:0] res1_simple, res2_simple;

  assign q_pop = (bstate_r == B_IDLE) && !q_empty;

  always_comb begin
    unique case (q_ctrl.kind)
      KIND_LEFT:   res1_simple = h_t;
      KIND_RIGHT:  res1_simple = sat_p(ext(h_t) - heat);
      default:     res1_simple = sat_p(ext(h_t) - ext(h_u));
    endcase
    unique case (q_ctrl.kind)
      KIND_LEFT:   res2_simple = h_u;
      KIND_RIGHT:  res2_simple = sat_p(ext(h_u) - heat);
      default:     res2_simple = sat_p(ext(h_u) - ext(h_t));
    endcase
  end

  // shared multiplier: each product is registered, then scaled and accumulated
  always_comb begin
    unique case (step_r)
      4'd0:    begin mul_a = dxx_r; mul_b = BW'(signed'({1'b0, coef_xx})); end
      4'd1:    begin mul_a = dyy_r; mul_b = BW'(signed'({1'b0, coef_yy})); end
      4'd2:    begin mul_a = vxp_r; mul_b = BW'(dtl_r); end
      4'd3:    begin mul_a = vxm_r; mul_b = BW'(drt_r); end
      4'd4:    begin mul_a = vyp_r; mul_b = BW'(dtd_r); end
      4'd5:    begin mul_a = vym_r; mul_b = BW'(dut_r); end
      4'd6:    begin mul_a = ax_r;  mul_b = BW'(signed'({1'b0, step_y})); end
      4'd7:    begin mul_a = ay_r;  mul_b = BW'(signed'({1'b0, step_x})); end
      default: begin mul_a = tmp_r; mul_b = BW'(signed'({1'b0, prandtl})); end
    endcase
  end

  assign prod = MW'(mul_a) * MW'(mul_b);

  // shift with truncation toward zero, then saturate
  always_comb begin
    prod_sh = PW'(prod_r) >>> FRAC_BITS;
    if (prod_r[MW-1] && (prod_r[FRAC_BITS-1:0] != '0)) begin
      prod_sh = prod_sh + PW'(1);
    end
    mq = sat_p(prod_sh);
  end

  assign out_load = !out_valid || !out_stall;
  assign out_fire = ((bstate_r == B_OUT1) || (bstate_r == B_OUT2)) && out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r  <= B_IDLE;
      out_valid <= 1'b0;
      step_r    <= '0;
      phase_r   <= 1'b0;
    end else begin
      if (out_fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (bstate_r)
        B_IDLE: begin
          if (q_pop) begin
            step_r   <= '0;
            phase_r  <= 1'b0;
            bstate_r <= (q_ctrl.kind == KIND_INNER) ? B_MUL : B_OUT1;
          end
        end
        B_MUL: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            step_r <= step_r + 4'd1;
            if (step_r == LAST_STEP) bstate_r <= B_OUT1;
          end
        end
        B_OUT1: begin
          if (out_load) begin
            bstate_r <= ctrl_r.has_second ? B_OUT2 : B_IDLE;
          end
        end
        default: begin
          if (out_load) begin
            bstate_r <= B_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ctrl_r <= q_ctrl;
      res1_r <= res1_simple;
      res2_r <= res2_simple;
      dxx_r  <= sat_p((ext(h_t) <<< 1) - ext(h_l) - ext(h_r));
      dyy_r  <= sat_p((ext(h_t) <<< 1) - ext(h_d) - ext(h_u));
      dtl_r  <= sat_p(ext(h_t) - ext(h_l));
      drt_r  <= sat_p(ext(h_r) - ext(h_t));
      dtd_r  <= sat_p(ext(h_t) - ext(h_d));
      dut_r  <= sat_p(ext(h_u) - ext(h_t));
      vxp_r  <= h_vx[DW-1] ? '0 : h_vx;
      vxm_r  <= h_vx[DW-1] ? h_vx : '0;
      vyp_r  <= h_vy[DW-1] ? '0 : h_vy;
      vym_r  <= h_vy[DW-1] ? h_vy : '0;
    end
    if (bstate_r == B_MUL) begin
      if (!phase_r) begin
        prod_r <= prod;
      end else begin
        unique case (step_r)
          4'd0:    diff_r <= mq;
          4'd1:    diff_r <= sat_p(ext(diff_r) + ext(mq));
          4'd2:    tmp_r  <= mq;
          4'd3:    ax_r   <= sat_p(ext(tmp_r) + ext(mq));
          4'd4:    tmp_r  <= mq;
          4'd5:    ay_r   <= sat_p(ext(tmp_r) + ext(mq));
          4'd6:    tmp_r  <= mq;
          4'd7:    tmp_r  <= sat_p(ext(tmp_r) + ext(mq));
          default: res1_r <= sat_p(ext(diff_r) + ext(mq));
        endcase
      end
    end
    if (bstate_r == B_OUT1 && out_load) begin
      out_residual <= IO_W'(res1_r);
      out_res_col  <= ctrl_r.col;
      out_res_row  <= ctrl_r.row;
      out_last     <= !ctrl_r.has_second;
    end else if (bstate_r == B_OUT2 && out_load) begin
      out_residual <= IO_W'(res2_r);
      out_res_col  <= ctrl_r.col;
      out_res_row  <= ctrl_r.row + IDX_W'(1);
      out_last     <= 1'b1;
    end
  end

endmodule

>>> rtl/upwind_heat_residual_stencil_core.sv
// Streaming temperature residual: 5-point diffusion plus first-order upwind
// convection scaled by the Prandtl number, Q-format fixed point, saturating.
// Input channel (in_*): one grid point per transaction in raster order, column
// fastest: temperature, x and y velocity. Output channel (out_*): residual with
// its column and row. A row's residuals come out while the next row streams in;
// each point of the last row yields two transactions (point below, then the
// point itself, out_last set on the final one). The first row yields none.
// Config port (cfg_*): plain writes, only while the block is idle. Writing
// grid_width or grid_height restarts the frame at row 0, column 0.
// The front end reads the line stores for a point, then writes them back and
// hands the task to the queue; it takes the next point only after that hand-off,
// which waits while a task is due and the queue is full. Edge-rule residuals go
// from the queue head through B_OUT1 to the output register; interior residuals
// first take nine passes through the single shared multiplier. A 2-entry task
// queue between front and back lets input keep flowing while the back end works.
// The back end pops a new task only once the last task's residuals are loaded.
// out_stall holds the output register; the back end and then the queue fill up,
// after which in_stall stays high. Reset clears counters, queue and output valid;
// line stores keep their contents and hold garbage until first written.
module upwind_heat_residual_stencil_core import uhrs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IO_W-1:0] in_temperature,
  input  logic signed [IO_W-1:0] in_vel_x,
  input  logic signed [IO_W-1:0] in_vel_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [IO_W-1:0] out_residual,
  output logic [IDX_W-1:0]       out_res_col,
  output logic [IDX_W-1:0]       out_res_row,
  output logic                   out_last,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int QW = CTRL_W + 7 * DATA_WIDTH;

  // configuration registers
  logic [CFG_SIZE_W-1:0] grid_width_r, grid_height_r;
  logic [COEF_W-1:0]     coef_xx_r, coef_yy_r, prandtl_r;
  logic [STEP_W-1:0]     step_x_r, step_y_r;
  logic                  heated_r;
  logic                  size_wr;

  assign size_wr = cfg_wr_en &&
                   ((cfg_index == CFG_GRID_WIDTH) || (cfg_index == CFG_GRID_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_SIZE_W'(1024);
      grid_height_r <= CFG_SIZE_W'(1024);
      coef_xx_r     <= COEF_W'(65536);
      coef_yy_r     <= COEF_W'(65536);
      step_x_r      <= STEP_W'(64);
      step_y_r      <= STEP_W'(64);
      prandtl_r     <= COEF_W'(65536);
      heated_r      <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[CFG_SIZE_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata[CFG_SIZE_W-1:0];
        CFG_COEF_XX:     coef_xx_r     <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_YY:     coef_yy_r     <= cfg_wdata[COEF_W-1:0];
        CFG_STEP_X:      step_x_r      <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_Y:      step_y_r      <= cfg_wdata[STEP_W-1:0];
        CFG_PRANDTL:     prandtl_r     <= cfg_wdata[COEF_W-1:0];
        default:         heated_r      <= cfg_wdata[0];
      endcase
    end
  end

  // front end -> task queue -> back end
  logic                    q_push, q_full, q_pop, q_empty;
  task_ctrl_t              push_ctrl, head_ctrl;
  logic [7*DATA_WIDTH-1:0] push_data;
  logic [QW-1:0]           q_head;

  uhrs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_temperature (in_temperature),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .size_wr        (size_wr),
    .grid_width     (grid_width_r),
    .grid_height    (grid_height_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_ctrl         (push_ctrl),
    .q_data         (push_data)
  );

  uhrs_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_ctrl, push_data}),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  assign head_ctrl = task_ctrl_t'(q_head[QW-1 -: CTRL_W]);

  uhrs_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_ctrl       (head_ctrl),
    .q_data       (q_head[7*DATA_WIDTH-1:0]),
    .coef_xx      (coef_xx_r),
    .coef_yy      (coef_yy_r),
    .step_x       (step_x_r),
    .step_y       (step_y_r),
    .prandtl      (prandtl_r),
    .heated_flag  (heated_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_residual (out_residual),
    .out_res_col  (out_res_col),
    .out_res_row  (out_res_row),
    .out_last     (out_last)
  );

endmodule

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
  import uhrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LINE_DEPTH  = 1024;
  localparam int  Q_FRAC      = 16;
  localparam int  DRAIN_WAIT  = 64;       // back end latency plus task queue, with margin
  localparam int  HOLD_CYCLES = 400;      // long receiver hold-off
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint DMAX = 64'sd2147483647;
  localparam longint DMIN = -64'sd2147483648;

  typedef struct {
    logic signed [IO_W-1:0] residual;
    logic [IDX_W-1:0]       col;
    logic [IDX_W-1:0]       row;
    logic                   last;
  } residual_t;

  // Scoreboard: mirrors the stencil datapath and holds residuals not yet seen.
  class residual_scoreboard;
    residual_t pending[$];
    int        errors;
    longint    temp_prev[LINE_DEPTH];
    longint    temp_prev2[LINE_DEPTH];
    longint    velx_prev[LINE_DEPTH];
    longint    vely_prev[LINE_DEPTH];
    int unsigned col_cnt, row_cnt;
    int unsigned grid_w, grid_h, cxx, cyy, sx, sy, pr, heated;

    function new();
      foreach (temp_prev[k]) begin
        temp_prev[k] = 0; temp_prev2[k] = 0; velx_prev[k] = 0; vely_prev[k] = 0;
      end
      col_cnt = 0; row_cnt = 0; errors = 0;
      grid_w = 1024; grid_h = 1024; cxx = 65536; cyy = 65536;
      sx = 64; sy = 64; pr = 65536; heated = 1;
    endfunction

    function longint sat(longint v);
      if (v > DMAX) return DMAX;
      if (v < DMIN) return DMIN;
      return v;
    endfunction

    // exact product, shift truncating toward zero, then saturate
    function longint qmul(longint a, longint b);
      return sat((a * b) / (64'sd1 << Q_FRAC));
    endfunction

    function int unsigned clamp_size(int unsigned v);
      if (v < 3) return 3;
      return (v > LINE_DEPTH) ? LINE_DEPTH : v;
    endfunction

    function void reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_GRID_WIDTH:  begin grid_w = val[CFG_SIZE_W-1:0]; col_cnt = 0; row_cnt = 0; end
        CFG_GRID_HEIGHT: begin grid_h = val[CFG_SIZE_W-1:0]; col_cnt = 0; row_cnt = 0; end
        CFG_COEF_XX:     cxx = val[COEF_W-1:0];
        CFG_COEF_YY:     cyy = val[COEF_W-1:0];
        CFG_STEP_X:      sx = val[STEP_W-1:0];
        CFG_STEP_Y:      sy = val[STEP_W-1:0];
        CFG_PRANDTL:     pr = val[COEF_W-1:0];
        CFG_HEATED:      heated = val[0];
        default: ;
      endcase
    endfunction

    function longint inner_residual(longint t, longint l, longint r, longint d,
                                    longint u, longint vx, longint vy);
      longint dxx, dyy, ax, ay, cx, cy, conv;
      dxx = qmul(sat(2 * t - l - r), longint'(cxx));
      dyy = qmul(sat(2 * t - d - u), longint'(cyy));
      ax  = sat(qmul(vx > 0 ? vx : 0, sat(t - l)) + qmul(vx < 0 ? vx : 0, sat(r - t)));
      ay  = sat(qmul(vy > 0 ? vy : 0, sat(t - d)) + qmul(vy < 0 ? vy : 0, sat(u - t)));
      cx  = qmul(ax, longint'(sy));
      cy  = qmul(ay, longint'(sx));
      conv = qmul(sat(cx + cy), longint'(pr));
      return sat(sat(dxx + dyy) + conv);
    endfunction

    function void push(longint v, int unsigned c, int unsigned r, bit lst);
      residual_t e;
      e.residual = v[IO_W-1:0];
      e.col = c[IDX_W-1:0];
      e.row = r[IDX_W-1:0];
      e.last = lst;
      pending.push_back(e);
    endfunction

    function void note_point(logic signed [IO_W-1:0] t_in, vx_in, vy_in);
      int unsigned w, h, i, j, il, ir;
      longint tn, t, v, heat;
      w = clamp_size(grid_w); h = clamp_size(grid_h);
      i = col_cnt; j = row_cnt;
      il = (i + LINE_DEPTH - 1) % LINE_DEPTH;
      ir = (i + 1) % LINE_DEPTH;
      tn = t_in;
      heat = longint'(heated) << Q_FRAC;
      if (j >= 1) begin
        t = temp_prev[i];
        if (i == 0) v = t;
        else if (i == w - 1) v = sat(t - heat);
        else if (j == 1) v = sat(t - tn);
        else v = inner_residual(t, temp_prev2[il], temp_prev[ir], temp_prev2[i], tn,
                                velx_prev[i], vely_prev[i]);
        push(v, i, j - 1, j != h - 1);
        if (j == h - 1) begin
          if (i == 0) v = tn;
          else if (i == w - 1) v = sat(tn - heat);
          else v = sat(tn - t);
          push(v, i, j, 1'b1);
        end
      end
      temp_prev2[i] = temp_prev[i];
      temp_prev[i] = tn;
      velx_prev[i] = vx_in;
      vely_prev[i] = vy_in;
      col_cnt = i + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = j + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function void check_result(logic signed [IO_W-1:0] res, logic [IDX_W-1:0] c,
                               logic [IDX_W-1:0] r, logic lst);
      residual_t e;
      if (pending.size() == 0) begin
        $error("unexpected residual %0d at col %0d row %0d", res, c, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (res !== e.residual) begin
        $error("residual: expected %0d, got %0d", e.residual, res); errors++;
      end
      if (c !== e.col) begin
        $error("res_col: expected %0d, got %0d", e.col, c); errors++;
      end
      if (r !== e.row) begin
        $error("res_row: expected %0d, got %0d", e.row, r); errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, lst); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IO_W-1:0] in_temperature = '0;
  logic signed [IO_W-1:0] in_vel_x = '0;
  logic signed [IO_W-1:0] in_vel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [IO_W-1:0] out_residual;
  logic [IDX_W-1:0] out_res_col;
  logic [IDX_W-1:0] out_res_row;
  logic out_last;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  residual_scoreboard sb = new();

  // idle rates in percent, set per phase by the stimulus
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;     // bump to request one long receiver hold-off
  longint cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  upwind_heat_residual_stencil_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_temperature(in_temperature), .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_residual(out_residual), .out_res_col(out_res_col),
    .out_res_row(out_res_row), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Monitor: predict on every input transaction, check every output transaction.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_point(in_temperature, in_vel_x, in_vel_y);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_residual, out_res_col, out_res_row, out_last);
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk) begin : recv_proc
    static int hold_left = 0;
    static int token_seen = 0;
    if (hold_token != token_seen) begin
      token_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one input transaction; may leave a random gap behind it
  task automatic send_point(input logic [IO_W-1:0] t, vx, vy);
    int gap;
    in_valid <= 1'b1;
    in_temperature <= t;
    in_vel_x <= vx;
    in_vel_y <= vy;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.reg_write(idx, val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait for every expected residual, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // data words: as often moderate as at the rails, some full-range
  function automatic logic [IO_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(5))
      0: return '0;
      1: return 31'h7fff_ffff;
      2: return CFG_DATA_W'($urandom() >> 1);
      default: return CFG_DATA_W'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(4))
      0: return '0;
      1: return 31'd65536;
      default: return CFG_DATA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic set_coefs();
    reg_write(CFG_COEF_XX, pick_coef());
    reg_write(CFG_COEF_YY, pick_coef());
    reg_write(CFG_STEP_X, pick_step());
    reg_write(CFG_STEP_Y, pick_step());
    reg_write(CFG_PRANDTL, pick_coef());
    reg_write(CFG_HEATED, CFG_DATA_W'($urandom_range(1)));
  endtask

  task automatic stream_points(input int n);
    repeat (n) send_point(pick_word(), pick_word(), pick_word());
  endtask

  initial begin : stimulus
    logic [IO_W-1:0] rails[5];
    int n_rand, w, h, mode, n_pts;
    rails = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000, 32'hffff_0000};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 5x4 frame with rail values, edge rows, edge columns, interior.
    reg_write(CFG_GRID_WIDTH, 31'd5);
    reg_write(CFG_GRID_HEIGHT, 31'd4);
    reg_write(CFG_COEF_XX, 31'd65536);
    reg_write(CFG_COEF_YY, 31'h7fff_ffff);
    reg_write(CFG_STEP_X, 31'd65536);
    reg_write(CFG_STEP_Y, 31'd0);
    reg_write(CFG_PRANDTL, 31'd65536);
    reg_write(CFG_HEATED, 31'd0);
    for (int k = 0; k < 20; k++)
      send_point(rails[k % 5], rails[(k + 1) % 5], rails[(k + 3) % 5]);
    drain();

    // Undersized grid clamps to 3x3.
    reg_write(CFG_GRID_WIDTH, 31'd0);
    reg_write(CFG_GRID_HEIGHT, 31'd2);
    reg_write(CFG_HEATED, 31'd1);
    stream_points(9);
    drain();

    // Oversized width clamps to the line store depth: a first row this long
    // must give no residuals; the next size write restarts the frame.
    reg_write(CFG_GRID_WIDTH, 31'd2047);
    reg_write(CFG_GRID_HEIGHT, 31'd0);
    set_coefs();
    stream_points(300);
    drain();

    // Tallest grid, cut short: the size write below restarts the frame mid-way.
    reg_write(CFG_GRID_WIDTH, 31'd3);
    reg_write(CFG_GRID_HEIGHT, 31'd2047);
    stream_points(3 * 20 + 1);
    drain();

    // Random phases cycle through idling modes.
    n_rand = 0;
    mode = 0;
    while (n_rand < 800) begin
      case (mode % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      reg_write(CFG_GRID_WIDTH, CFG_DATA_W'(w));
      reg_write(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
      set_coefs();
      w = sb.clamp_size(w);
      h = sb.clamp_size(h);
      if (mode == 1) begin
        // receiver holds off long while points keep coming: input must stall
        hold_token++;
        stream_points(2 * w * h);
        // sender pauses mid-frame until every expected residual is out
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
        stream_points(w * h);
        n_rand += 3 * w * h;
      end else begin
        n_pts = $urandom_range(1, 3) * w * h;
        stream_points(n_pts);
        n_rand += n_pts;
      end
      drain();
      mode++;
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
